FILE: hdl/tee_pkg.sv
// shared constants, types and item layouts for the tween easing evaluator
package tee_pkg;

  localparam int NEWTON_STEPS  = 8;
  localparam int FRACTION_BITS = 16;

  localparam int TIME_W  = 24;
  localparam int VALUE_W = 32;
  localparam int PROG_W  = FRACTION_BITS + 1;
  localparam int TMP_W   = (FRACTION_BITS + 6 > 24) ? FRACTION_BITS + 6 : 24;
  localparam int DIFF_W  = VALUE_W + 2;
  localparam int PROD_W  = DIFF_W + TMP_W;
  localparam int FMUL_W  = PROD_W - FRACTION_BITS;
  localparam int QUO_W   = FRACTION_BITS + 2;
  localparam int DEN_W   = (TMP_W > TIME_W) ? TMP_W : TIME_W;
  localparam int NUM_W   = DEN_W + FRACTION_BITS;
  localparam int ITER_W  = $clog2(NEWTON_STEPS + 1);
  localparam int DCNT_W  = $clog2(QUO_W);

  localparam longint ONE_L      = 64'sd1 << FRACTION_BITS;
  localparam longint HALF_L     = ONE_L / 2;
  localparam longint C1_L       = (170158 * ONE_L + 50000) / 100000;
  localparam longint C3_L       = C1_L + ONE_L;
  localparam longint EPSX_L     = ((ONE_L + 50000) / 100000 > 0) ? (ONE_L + 50000) / 100000 : 1;
  localparam longint EPSS_L     = ((ONE_L + 500000) / 1000000 > 0) ?
                                  (ONE_L + 500000) / 1000000 : 1;
  localparam longint EASE_MAX_L = 8 * ONE_L - 1;
  localparam longint EASE_MIN_L = -8 * ONE_L;
  localparam longint VMAX_L     = 64'sd2147483647;
  localparam longint VMIN_L     = -64'sd2147483648;

  typedef logic        [PROG_W-1:0] prog_t;
  typedef logic signed [TMP_W-1:0]  tmp_t;
  typedef logic signed [DIFF_W-1:0] mula_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [FMUL_W-1:0] fmul_t;
  typedef logic signed [FMUL_W:0]   vsum_t;
  typedef logic signed [TMP_W:0]    tupd_t;
  typedef logic        [QUO_W-1:0]  quo_t;
  typedef logic        [DEN_W-1:0]  den_t;
  typedef logic        [NUM_W-1:0]  num_t;
  typedef logic        [ITER_W-1:0] iter_t;
  typedef logic        [DCNT_W-1:0] dcnt_t;

  typedef enum logic [2:0] {
    MODE_LINEAR       = 3'd0,
    MODE_IN           = 3'd1,
    MODE_OUT          = 3'd2,
    MODE_IN_OUT       = 3'd3,
    MODE_OUT_QUART    = 3'd4,
    MODE_OUT_BACK     = 3'd5,
    MODE_IN_OUT_CUBIC = 3'd6,
    MODE_BEZIER       = 3'd7
  } mode_t;

  typedef struct packed {
    logic        [23:0] elapsed_time;
    logic        [23:0] delay_time;
    logic        [23:0] duration_time;
    logic signed [31:0] start_value;
    logic signed [31:0] target_value;
    logic        [2:0]  easing_mode;
    logic        [16:0] bezier_x1;
    logic signed [19:0] bezier_y1;
    logic        [16:0] bezier_x2;
    logic signed [19:0] bezier_y2;
  } tee_req_t;

  typedef struct packed {
    logic signed [31:0] current_value;
    logic        [16:0] raw_progress;
    logic signed [19:0] eased_progress;
    logic               tween_done;
  } tee_rsp_t;

endpackage

FILE: hdl/tee_in_if.sv
// request channel: valid, ready and one tween request
interface tee_in_if;
  logic              valid;
  logic              ready;
  tee_pkg::tee_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/tee_out_if.sv
// result channel: valid, ready and one evaluated tween value
interface tee_out_if;
  logic              valid;
  logic              ready;
  tee_pkg::tee_rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/tween_easing_evaluator.sv
// tween easing evaluator: raw progress, easing curve and interpolation, one shared multiplier
// A request transfer is taken only while the block is idle; it then works alone on that
// request and posts one result transfer. Raw progress uses a restoring divider unless the
// duration is zero or the tween has finished, which skip it. Simple curves then use the
// single multiplier, followed by the interpolation and the posting of the result; the
// block returns to idle before the next request is taken. The cubic-Bezier mode runs
// up to eight Newton steps on the same multiplier and divider, each step evaluating x(t),
// then the slope, the divide and the update; y(t) is evaluated last. The result sits in
// an output register, so a new request is taken while an earlier result still waits to
// be taken.
module tween_easing_evaluator (
  input logic       clk,
  input logic       rst,
  tee_in_if.sink    request,
  tee_out_if.source result
);

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_DIV, S_EASE, S_BEZ, S_SLOPE, S_UPDATE, S_VALUE, S_DONE
  } state_t;

  // fixed-point constants at the internal width
  localparam tee_pkg::tmp_t ONE_T  = tee_pkg::tmp_t'(tee_pkg::ONE_L);
  localparam tee_pkg::tmp_t C1_T   = tee_pkg::tmp_t'(tee_pkg::C1_L);
  localparam tee_pkg::tmp_t C3_T   = tee_pkg::tmp_t'(tee_pkg::C3_L);
  localparam tee_pkg::tmp_t EMAX_T = tee_pkg::tmp_t'(tee_pkg::EASE_MAX_L);
  localparam tee_pkg::tmp_t EMIN_T = tee_pkg::tmp_t'(tee_pkg::EASE_MIN_L);
  localparam tee_pkg::prog_t ONE_P  = tee_pkg::prog_t'(tee_pkg::ONE_L);
  localparam tee_pkg::prog_t HALF_P = tee_pkg::prog_t'(tee_pkg::HALF_L);
  localparam tee_pkg::den_t EPSX_D  = tee_pkg::den_t'(tee_pkg::EPSX_L);
  localparam tee_pkg::den_t EPSS_D  = tee_pkg::den_t'(tee_pkg::EPSS_L);
  localparam tee_pkg::dcnt_t DLAST  = tee_pkg::dcnt_t'(tee_pkg::QUO_W - 1);
  localparam tee_pkg::iter_t ITLAST = tee_pkg::iter_t'(tee_pkg::NEWTON_STEPS);
  localparam tee_pkg::vsum_t VMAX_V = tee_pkg::vsum_t'(tee_pkg::VMAX_L);
  localparam tee_pkg::vsum_t VMIN_V = tee_pkg::vsum_t'(tee_pkg::VMIN_L);

  state_t            state;
  logic [2:0]        step;
  tee_pkg::tee_req_t req;
  tee_pkg::prog_t    raw;
  tee_pkg::tmp_t     t, x1c, x2c;
  tee_pkg::tmp_t     q0, q1, q2, r0, r1, r2;
  tee_pkg::tmp_t     acc, slope, ez;
  tee_pkg::iter_t    iter;
  logic              ypass, div_raw, dneg, dsat;
  tee_pkg::den_t     drem, dden;
  tee_pkg::quo_t     dlow, dq;
  tee_pkg::dcnt_t    dcnt;
  logic signed [31:0] cur;
  logic              out_valid;
  tee_pkg::tee_rsp_t out_data;

  // saturate the eased progress to its output range
  function automatic tee_pkg::tmp_t sat_ease(tee_pkg::tmp_t v);
    tee_pkg::tmp_t r;
    if (v > EMAX_T) r = EMAX_T;
    else if (v < EMIN_T) r = EMIN_T;
    else r = v;
    return r;
  endfunction

  function automatic tee_pkg::den_t abs_of(tee_pkg::tmp_t v);
    tee_pkg::tmp_t a;
    a = v[tee_pkg::TMP_W-1] ? -v : v;
    return tee_pkg::den_t'(unsigned'(a));
  endfunction

  // ---------------------------------------------------------------- datapath helpers
  logic [23:0]     local_time;
  tee_pkg::tmp_t   c_t, m_t, p1, p2, ez_sat, pt, pt3, pt6, bz_sum, bz_err;
  tee_pkg::tmp_t   x1_in, x2_in;
  logic            lo_half;
  tee_pkg::mode_t  mode;
  tee_pkg::mula_t  mul_a;
  tee_pkg::tmp_t   mul_b;
  tee_pkg::prod_t  prod;
  tee_pkg::fmul_t  pf;
  tee_pkg::vsum_t  vsum;
  logic signed [31:0] vclamp;
  tee_pkg::den_t   acc_abs, slope_abs, err_abs, ld_mag, ld_rem, rem_next;
  tee_pkg::num_t   ld_num;
  tee_pkg::quo_t   dq_next;
  logic [tee_pkg::DEN_W:0] trial;
  logic            ge;
  tee_pkg::tupd_t  tn;
  tee_pkg::tmp_t   t_upd;

  assign local_time = (req.elapsed_time > req.delay_time) ?
                      req.elapsed_time - req.delay_time : '0;
  assign mode    = tee_pkg::mode_t'(req.easing_mode);
  assign c_t     = tee_pkg::tmp_t'($signed({1'b0, raw}));
  assign m_t     = ONE_T - t;
  assign lo_half = raw < HALF_P;
  assign p1      = ypass ? tee_pkg::tmp_t'(req.bezier_y1) : x1c;
  assign p2      = ypass ? tee_pkg::tmp_t'(req.bezier_y2) : x2c;
  assign ez_sat  = sat_ease(ez);
  assign x1_in   = tee_pkg::tmp_t'($signed({1'b0, req.bezier_x1}));
  assign x2_in   = tee_pkg::tmp_t'($signed({1'b0, req.bezier_x2}));

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_EASE: begin
        case (mode)
          tee_pkg::MODE_IN: begin
            mul_a = tee_pkg::mula_t'(c_t);
            mul_b = c_t;
          end
          tee_pkg::MODE_OUT: begin
            mul_a = tee_pkg::mula_t'(c_t);
            mul_b = (ONE_T <<< 1) - c_t;
          end
          tee_pkg::MODE_IN_OUT: begin
            mul_a = lo_half ? tee_pkg::mula_t'(c_t) :
                              tee_pkg::mula_t'((ONE_T <<< 2) - (c_t <<< 1));
            mul_b = c_t;
          end
          tee_pkg::MODE_OUT_QUART: begin
            if (step == 3'd0) begin
              mul_a = tee_pkg::mula_t'(ONE_T - c_t);
              mul_b = ONE_T - c_t;
            end else begin
              mul_a = tee_pkg::mula_t'(r0);
              mul_b = r0;
            end
          end
          tee_pkg::MODE_OUT_BACK: begin
            case (step)
              3'd0: begin
                mul_a = tee_pkg::mula_t'(c_t - ONE_T);
                mul_b = c_t - ONE_T;
              end
              3'd1: begin
                mul_a = tee_pkg::mula_t'(r0);
                mul_b = c_t - ONE_T;
              end
              3'd2: begin
                mul_a = tee_pkg::mula_t'(C3_T);
                mul_b = r1;
              end
              default: begin
                mul_a = tee_pkg::mula_t'(C1_T);
                mul_b = r0;
              end
            endcase
          end
          tee_pkg::MODE_IN_OUT_CUBIC: begin
            if (lo_half) begin
              mul_a = (step == 3'd0) ? tee_pkg::mula_t'(c_t) : tee_pkg::mula_t'(r0);
              mul_b = c_t;
            end else begin
              mul_a = (step == 3'd0) ? tee_pkg::mula_t'((ONE_T <<< 1) - (c_t <<< 1)) :
                                       tee_pkg::mula_t'(r0);
              mul_b = (ONE_T <<< 1) - (c_t <<< 1);
            end
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      S_BEZ: begin
        case (step)
          3'd0: begin mul_a = tee_pkg::mula_t'(m_t); mul_b = m_t; end
          3'd1: begin mul_a = tee_pkg::mula_t'(m_t); mul_b = t;   end
          3'd2: begin mul_a = tee_pkg::mula_t'(t);   mul_b = t;   end
          3'd3: begin mul_a = tee_pkg::mula_t'(q0);  mul_b = t;   end
          3'd4: begin mul_a = tee_pkg::mula_t'(q1);  mul_b = t;   end
          3'd5: begin mul_a = tee_pkg::mula_t'(q2);  mul_b = t;   end
          3'd6: begin mul_a = tee_pkg::mula_t'(r0);  mul_b = p1;  end
          default: begin mul_a = tee_pkg::mula_t'(r1); mul_b = p2; end
        endcase
      end
      S_SLOPE: begin
        case (step)
          3'd0: begin mul_a = tee_pkg::mula_t'(q0); mul_b = x1c;         end
          3'd1: begin mul_a = tee_pkg::mula_t'(q1); mul_b = x2c - x1c;   end
          3'd2: begin mul_a = tee_pkg::mula_t'(q2); mul_b = ONE_T - x2c; end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      S_VALUE: begin
        mul_a = tee_pkg::mula_t'(req.target_value) - tee_pkg::mula_t'(req.start_value);
        mul_b = ez_sat;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // floored fixed-point product: arithmetic shift drops the fraction
  assign prod = tee_pkg::prod_t'(mul_a) * tee_pkg::prod_t'(mul_b);
  assign pf   = $signed(prod[tee_pkg::PROD_W-1:tee_pkg::FRACTION_BITS]);
  assign pt   = $signed(pf[tee_pkg::TMP_W-1:0]);
  assign pt3  = pt + (pt <<< 1);
  assign pt6  = pt3 <<< 1;

  // bezier sum and the error against the wanted x
  assign bz_sum  = acc + pt3;
  assign bz_err  = bz_sum - c_t;
  assign err_abs = abs_of(bz_err);

  // interpolation with saturation to the 32-bit value range
  assign vsum   = tee_pkg::vsum_t'(req.start_value) + tee_pkg::vsum_t'(pf);
  assign vclamp = (vsum > VMAX_V) ? 32'sh7FFFFFFF :
                  (vsum < VMIN_V) ? 32'sh80000000 : vsum[31:0];

  // restoring divider, one quotient bit a cycle
  assign acc_abs   = abs_of(acc);
  assign slope_abs = abs_of(slope);
  assign ld_mag    = (state == S_PREP) ? tee_pkg::den_t'(local_time) : acc_abs;
  assign ld_num    = tee_pkg::num_t'(ld_mag) << tee_pkg::FRACTION_BITS;
  assign ld_rem    = tee_pkg::den_t'(ld_num[tee_pkg::NUM_W-1:tee_pkg::QUO_W]);
  assign trial     = {drem, dlow[tee_pkg::QUO_W-1]};
  assign ge        = trial >= {1'b0, dden};
  assign rem_next  = ge ? tee_pkg::den_t'(trial - {1'b0, dden}) : tee_pkg::den_t'(trial);
  assign dq_next   = {dq[tee_pkg::QUO_W-2:0], ge};

  // newton update of t, clamped to 0..one; an overflowing quotient pins t to an end
  assign tn = dneg ? (tee_pkg::tupd_t'(t) + tee_pkg::tupd_t'($signed({1'b0, dq}))) :
                     (tee_pkg::tupd_t'(t) - tee_pkg::tupd_t'($signed({1'b0, dq})));
  always_comb begin
    if (dsat) t_upd = dneg ? ONE_T : '0;
    else if (tn < 0) t_upd = '0;
    else if (tn > tee_pkg::tupd_t'(ONE_T)) t_upd = ONE_T;
    else t_upd = tee_pkg::tmp_t'(tn);
  end

  assign request.ready = (state == S_IDLE);
  assign result.valid  = out_valid;
  assign result.data   = out_data;

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      // output register: load a new result or drop a taken one
      if (state == S_DONE && (!out_valid || result.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (request.valid) begin
            req   <= request.data;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          step <= '0;
          if (req.duration_time == '0) begin
            raw   <= (local_time != '0) ? ONE_P : '0;
            state <= S_EASE;
          end else if (local_time >= req.duration_time) begin
            raw   <= ONE_P;
            state <= S_EASE;
          end else begin
            div_raw <= 1'b1;
            drem    <= ld_rem;
            dlow    <= ld_num[tee_pkg::QUO_W-1:0];
            dden    <= tee_pkg::den_t'(req.duration_time);
            dq      <= '0;
            dcnt    <= '0;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          drem <= rem_next;
          dlow <= dlow << 1;
          dq   <= dq_next;
          dcnt <= dcnt + 1'b1;
          if (dcnt == DLAST) begin
            if (div_raw) begin
              raw   <= tee_pkg::prog_t'(dq_next);
              step  <= '0;
              state <= S_EASE;
            end else begin
              state <= S_UPDATE;
            end
          end
        end
        S_EASE: begin
          case (mode)
            tee_pkg::MODE_LINEAR: begin
              ez    <= c_t;
              state <= S_VALUE;
            end
            tee_pkg::MODE_IN, tee_pkg::MODE_OUT: begin
              ez    <= pt;
              state <= S_VALUE;
            end
            tee_pkg::MODE_IN_OUT: begin
              ez    <= lo_half ? (pt <<< 1) : (pt - ONE_T);
              state <= S_VALUE;
            end
            tee_pkg::MODE_OUT_QUART: begin
              if (step == 3'd0) begin
                r0   <= pt;
                step <= 3'd1;
              end else begin
                ez    <= ONE_T - pt;
                state <= S_VALUE;
              end
            end
            tee_pkg::MODE_OUT_BACK: begin
              case (step)
                3'd0: r0 <= pt;
                3'd1: r1 <= pt;
                3'd2: r2 <= pt;
                default: begin
                  ez    <= ONE_T + r2 + pt;
                  state <= S_VALUE;
                end
              endcase
              step <= step + 1'b1;
            end
            tee_pkg::MODE_IN_OUT_CUBIC: begin
              if (step == 3'd0) begin
                r0   <= pt;
                step <= 3'd1;
              end else begin
                ez    <= lo_half ? (pt <<< 2) : (ONE_T - (pt >>> 1));
                state <= S_VALUE;
              end
            end
            default: begin
              // bezier: control x clamped to 0..one, newton starts at t = progress
              x1c   <= (x1_in > ONE_T) ? ONE_T : x1_in;
              x2c   <= (x2_in > ONE_T) ? ONE_T : x2_in;
              t     <= c_t;
              iter  <= '0;
              ypass <= 1'b0;
              step  <= '0;
              state <= S_BEZ;
            end
          endcase
        end
        S_BEZ: begin
          // step wraps from seven back to zero for the next pass
          step <= step + 1'b1;
          case (step)
            3'd0: q0 <= pt;
            3'd1: q1 <= pt;
            3'd2: q2 <= pt;
            3'd3: r0 <= pt;
            3'd4: r1 <= pt;
            3'd5: r2 <= pt;
            3'd6: acc <= r2 + pt3;
            default: begin
              if (ypass) begin
                ez    <= bz_sum;
                state <= S_VALUE;
              end else if (err_abs < EPSX_D) begin
                ypass <= 1'b1;
              end else begin
                acc   <= bz_err;
                state <= S_SLOPE;
              end
            end
          endcase
        end
        S_SLOPE: begin
          step <= (step == 3'd3) ? 3'd0 : step + 1'b1;
          case (step)
            3'd0: slope <= pt3;
            3'd1: slope <= slope + pt6;
            3'd2: slope <= slope + pt3;
            default: begin
              if (slope_abs < EPSS_D) begin
                ypass <= 1'b1;
                state <= S_BEZ;
              end else begin
                dneg    <= acc[tee_pkg::TMP_W-1] ^ slope[tee_pkg::TMP_W-1];
                dsat    <= acc_abs >= (slope_abs << 2);
                div_raw <= 1'b0;
                drem    <= ld_rem;
                dlow    <= ld_num[tee_pkg::QUO_W-1:0];
                dden    <= slope_abs;
                dq      <= '0;
                dcnt    <= '0;
                state   <= (acc_abs >= (slope_abs << 2)) ? S_UPDATE : S_DIV;
              end
            end
          endcase
        end
        S_UPDATE: begin
          t     <= t_upd;
          iter  <= iter + 1'b1;
          ypass <= (iter + 1'b1) == ITLAST;
          step  <= '0;
          state <= S_BEZ;
        end
        S_VALUE: begin
          cur   <= vclamp;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || result.ready) begin
            out_data.current_value   <= cur;
            out_data.raw_progress    <= 17'(raw);
            out_data.eased_progress  <= ez_sat[19:0];
            out_data.tween_done      <= (raw == ONE_P);
            state                    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
